// File: sv/telemetry_stubborn_sender_macros.svh
// Assertion macros shared by the sender RTL.
`ifndef TELEMETRY_STUBBORN_SENDER_MACROS_SVH
`define TELEMETRY_STUBBORN_SENDER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tss_pkg.sv
// Types and constants for the telemetry stubborn sender.
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_SEND        = 3'd1,
        PH_WAIT        = 3'd2,
        PH_RESYNC      = 3'd3,
        PH_RESYNC_SEND = 3'd4
    } phase_t;

    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_CONFIRM = 2'd1;
    localparam logic [1:0] FUNC_QUERY   = 2'd2;

    localparam logic [15:0] MAX_WAIT_RESET = 16'd80;
    localparam logic [15:0] MISS_SAT       = 16'hFFFF;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] msg_length;
        logic [7:0] chunk_bytes;
        logic       confirm_bit;
    } item_t;

    typedef struct packed {
        logic       accepted;
        logic [3:0] pkg_index;
        logic [7:0] byte_count;
        logic [7:0] byte_offset;
        logic       busy_res;
        phase_t     phase;
    } result_t;

endpackage

`default_nettype wire

// File: sv/tss_engine.sv
// Sender state registers, per-beat state update and descriptor logic.
`timescale 1ns / 1ps
`default_nettype none

`include "telemetry_stubborn_sender_macros.svh"

module tss_engine
    import tss_pkg::*;
#(
    parameter int unsigned MAX_PACKAGES = 15
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire item_t       item,
    input  wire logic [15:0] max_wait,
    output result_t          result
);

    localparam int MP_W   = $clog2(MAX_PACKAGES + 1);
    localparam int PROD_W = 8 + MP_W;

    phase_t      phase_reg,    phase_next;
    logic [7:0]  length_reg,   length_next;
    logic [7:0]  chunk_reg,    chunk_next;
    logic [8:0]  offset_reg,   offset_next;
    logic [3:0]  package_reg,  package_next;
    logic        expect_reg,   expect_next;
    logic [15:0] miss_reg,     miss_next;

    logic [PROD_W-1:0] limit_bytes;
    logic              start_ok;
    logic [15:0]       miss_inc;
    logic              miss_over;
    logic [9:0]        end_sum;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            length_reg  <= '0;
            chunk_reg   <= 8'd1;
            offset_reg  <= '0;
            package_reg <= '0;
            expect_reg  <= 1'b1;
            miss_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            chunk_reg   <= chunk_next;
            offset_reg  <= offset_next;
            package_reg <= package_next;
            expect_reg  <= expect_next;
            miss_reg    <= miss_next;
        end
    end

    // len / chunk < MAX  <=>  len < MAX * chunk, for chunk != 0
    assign limit_bytes = PROD_W'(item.chunk_bytes) * PROD_W'(MAX_PACKAGES);
    assign start_ok    = (item.chunk_bytes != 8'd0) && (PROD_W'(item.msg_length) < limit_bytes);
    assign miss_inc    = (miss_reg == MISS_SAT) ? miss_reg : miss_reg + 16'd1;
    assign miss_over   = miss_inc > max_wait;

    always_comb begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        chunk_next   = chunk_reg;
        offset_next  = offset_reg;
        package_next = package_reg;
        expect_next  = expect_reg;
        miss_next    = miss_reg;

        if (item.func == FUNC_START)
        begin
            if (start_ok)
            begin
                length_next  = item.msg_length;
                chunk_next   = item.chunk_bytes;
                offset_next  = '0;
                package_next = 4'd1;
                miss_next    = '0;
                phase_next   = (phase_reg == PH_IDLE) ? PH_SEND : PH_RESYNC_SEND;
            end
        end
        else if (item.func == FUNC_CONFIRM)
        begin
            unique case (phase_reg)
                PH_SEND:
                begin
                    if (item.confirm_bit != expect_reg)
                    begin
                        miss_next = miss_inc;
                        if (miss_over)
                        begin
                            expect_next = ~item.confirm_bit;
                            phase_next  = PH_RESYNC;
                        end
                    end
                    else
                    begin
                        offset_next  = offset_reg + {1'b0, chunk_reg};
                        package_next = package_reg + 4'd1;
                        expect_next  = ~expect_reg;
                        miss_next    = '0;
                        if (offset_next >= {1'b0, length_reg})
                            phase_next = PH_WAIT;
                    end
                end
                PH_WAIT, PH_RESYNC, PH_RESYNC_SEND:
                begin
                    if (item.confirm_bit == expect_reg)
                    begin
                        phase_next  = (phase_reg == PH_RESYNC_SEND) ? PH_SEND : PH_IDLE;
                        expect_next = ~item.confirm_bit;
                    end
                    else if (phase_reg == PH_WAIT)
                    begin
                        miss_next = miss_inc;
                        if (miss_over)
                        begin
                            expect_next = ~item.confirm_bit;
                            phase_next  = PH_RESYNC;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Descriptor after the beat has been applied
    assign end_sum = {1'b0, offset_next} + {2'b00, chunk_next};

    always_comb begin
        result           = '0;
        result.accepted  = (item.func == FUNC_START) && start_ok;
        result.busy_res  = (phase_next != PH_IDLE);
        result.phase     = phase_next;
        if (phase_next == PH_RESYNC || phase_next == PH_RESYNC_SEND)
        begin
            result.pkg_index = 4'(MAX_PACKAGES);
        end
        else if (phase_next == PH_SEND)
        begin
            result.pkg_index   = package_next;
            result.byte_offset = offset_next[7:0];
            if (chunk_next > 8'd1)
            begin
                if (end_sum <= {2'b00, length_next})
                    result.byte_count = chunk_next;
                else if ({1'b0, length_next} >= offset_next)
                    result.byte_count = 8'({1'b0, length_next} - offset_next);
                else
                    result.byte_count = 8'd0;
            end
            else
            begin
                result.byte_count = 8'd1;
            end
        end
    end

    `TSS_ASSERT_NOW(a_accept_is_start, result.accepted, item.func == FUNC_START, "accept without start")
    `TSS_ASSERT_NEXT(a_accept_goes_send, step && result.accepted,
        phase_reg == PH_SEND || phase_reg == PH_RESYNC_SEND, "start taken but not sending")
    `TSS_ASSERT_NEXT(a_hold_no_step, !step,
        $stable(phase_reg) && $stable(offset_reg) && $stable(miss_reg), "state moved without beat")
    `TSS_ASSERT_NEXT(a_miss_saturates, step && miss_reg == MISS_SAT,
        miss_reg == MISS_SAT || miss_reg == 16'd0, "miss count wrapped")

endmodule

`default_nettype wire

// File: sv/telemetry_stubborn_sender.sv
// Top level of the telemetry stubborn sender: handshake stages and config register.
`timescale 1ns / 1ps
`default_nettype none

// Stubborn sender descriptor engine. Each input beat is a start (length and
// chunk size), a confirm toggle from the partner, or a query; each returns one
// result beat with the package index, byte count and offset to send next plus
// the sender phase. Starts whose length is MAX_PACKAGES times the chunk size
// or more, or with chunk size zero, are refused. Payload bytes are held outside.
// Timing: one beat per clock while out_ready stays high; a beat is registered
// in the input register and its result in the output register when it advances,
// on the same edge as the state update. Both stages pass on when the stage
// ahead is empty or being drained; while a result waits on out_ready the input
// register takes one more beat, then in_ready drops until the result goes.
// max_wait (reset 80) is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while the block is idle, the block itself does not enforce this.

`include "telemetry_stubborn_sender_macros.svh"

module telemetry_stubborn_sender
    import tss_pkg::*;
#(
    parameter int unsigned MAX_PACKAGES = 15
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  msg_length,
    input  wire logic [7:0]  chunk_bytes,
    input  wire logic        confirm_bit,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             accepted,
    output logic [3:0]       pkg_index,
    output logic [7:0]       byte_count,
    output logic [7:0]       byte_offset,
    output logic             busy_res,
    output logic [2:0]       phase,
    // config
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    logic        in_valid_reg;
    item_t       item_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    logic [15:0] max_wait_reg;
    logic        advance;
    result_t     result_next;

    // Input beat moves to the result stage when that stage is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_wait_reg  <= MAX_WAIT_RESET;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_wr_en)
                max_wait_reg <= cfg_wr_data;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk) begin
        if (in_ready && in_valid)
            item_reg <= '{func: func, msg_length: msg_length,
                          chunk_bytes: chunk_bytes, confirm_bit: confirm_bit};
        if (advance)
            result_reg <= result_next;
    end

    tss_engine #(
        .MAX_PACKAGES(MAX_PACKAGES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (item_reg),
        .max_wait (max_wait_reg),
        .result   (result_next)
    );

    assign out_valid   = out_valid_reg;
    assign accepted    = result_reg.accepted;
    assign pkg_index   = result_reg.pkg_index;
    assign byte_count  = result_reg.byte_count;
    assign byte_offset = result_reg.byte_offset;
    assign busy_res    = result_reg.busy_res;
    assign phase       = result_reg.phase;

    `TSS_ASSERT_NEXT(a_held_beat_kept, in_valid_reg && !advance, in_valid_reg, "held beat dropped")
    `TSS_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg, "result beat lost")
    `TSS_ASSERT_NOW(a_stall_blocks_in, in_valid_reg && out_valid_reg && !out_ready, !in_ready,
        "input taken while both stages full")

endmodule

`default_nettype wire

// File: tb/telemetry_stubborn_sender_tb.sv
// Self-checking testbench for the telemetry stubborn sender: queued stimulus, descriptor predictor.
`timescale 1ns / 1ps

module telemetry_stubborn_sender_tb;
    import tss_pkg::*;

    localparam int unsigned MAX_PKG     = 15;
    // func code the block does not define; it must behave as a query
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          PRINT_CAP   = 100;

    // Sender state as the predictor keeps it: 9-bit offset, wrapping package
    // number, saturating miss counter.
    typedef struct packed {
        phase_t      ph;
        logic [7:0]  len;
        logic [7:0]  chunk;
        logic [8:0]  off;
        logic [3:0]  pkg;
        logic        exp_c;
        logic [15:0] miss;
    } sender_state_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  func        = FUNC_QUERY;
    logic [7:0]  msg_length  = 8'd0;
    logic [7:0]  chunk_bytes = 8'd0;
    logic        confirm_bit = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        accepted;
    logic [3:0]  pkg_index;
    logic [7:0]  byte_count;
    logic [7:0]  byte_offset;
    logic        busy_res;
    logic [2:0]  phase;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;

    // Items still to be driven; the head is the beat currently on the bus.
    item_t         item_backlog [$];
    // Descriptors predicted for accepted input beats, oldest first.
    result_t       desc_due [$];

    // Two copies of the sender state: one follows accepted beats at the
    // bus, the other runs ahead while the stimulus is being planned so that
    // confirms can be aimed at the toggle the block will expect.
    sender_state_t mon_st;
    sender_state_t plan_st;
    logic [15:0]   mon_mw;
    logic [15:0]   plan_mw;
    result_t       plan_scratch;

    logic          in_beat = 1'b0;
    int            err_count = 0;
    int            burst_left = 1;
    int            gap_left = 0;
    int            rx_mode = 0;
    int            rx_mode_left = 0;
    int            stall_left = 0;

    telemetry_stubborn_sender #(
        .MAX_PACKAGES (MAX_PKG)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .msg_length  (msg_length),
        .chunk_bytes (chunk_bytes),
        .confirm_bit (confirm_bit),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .pkg_index   (pkg_index),
        .byte_count  (byte_count),
        .byte_offset (byte_offset),
        .busy_res    (busy_res),
        .phase       (phase),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic sender_state_t sender_reset_state();
        sender_state_t s;
        s.ph    = PH_IDLE;
        s.len   = 8'd0;
        s.chunk = 8'd1;
        s.off   = 9'd0;
        s.pkg   = 4'd0;
        s.exp_c = 1'b1;
        s.miss  = 16'd0;
        return s;
    endfunction

    function automatic item_t mk_item(input logic [1:0] f, input logic [7:0] l,
                                      input logic [7:0] c, input logic b);
        item_t it;
        it.func        = f;
        it.msg_length  = l;
        it.chunk_bytes = c;
        it.confirm_bit = b;
        return it;
    endfunction

    // Applies one beat to the state and returns the descriptor that is
    // current afterwards.
    function automatic result_t next_descriptor(inout sender_state_t s, input item_t it,
                                                input logic [15:0] mw);
        result_t r;
        r = '0;
        if (it.func == FUNC_START) begin
            if (it.chunk_bytes != 8'd0 && (it.msg_length / it.chunk_bytes) < MAX_PKG)
            begin
                r.accepted = 1'b1;
                s.len      = it.msg_length;
                s.chunk    = it.chunk_bytes;
                s.off      = 9'd0;
                s.pkg      = 4'd1;
                s.miss     = 16'd0;
                s.ph       = (s.ph == PH_IDLE) ? PH_SEND : PH_RESYNC_SEND;
            end
        end
        else if (it.func == FUNC_CONFIRM && s.ph != PH_IDLE) begin
            if (s.ph == PH_SEND && it.confirm_bit == s.exp_c) begin
                // right toggle: package delivered, move on
                s.off   = s.off + 9'(s.chunk);
                s.pkg   = s.pkg + 4'd1;
                s.exp_c = ~s.exp_c;
                s.miss  = 16'd0;
                if (s.off >= {1'b0, s.len})
                    s.ph = PH_WAIT;
            end
            else if (it.confirm_bit == s.exp_c) begin
                s.ph    = (s.ph == PH_RESYNC_SEND) ? PH_SEND : PH_IDLE;
                s.exp_c = ~it.confirm_bit;
            end
            else if (s.ph == PH_SEND || s.ph == PH_WAIT) begin
                if (s.miss != MISS_SAT)
                    s.miss = s.miss + 16'd1;
                if (s.miss > mw) begin
                    s.exp_c = ~it.confirm_bit;
                    s.ph    = PH_RESYNC;
                end
            end
        end

        unique case (s.ph)
            PH_RESYNC, PH_RESYNC_SEND:
                r.pkg_index = 4'(MAX_PKG);
            PH_SEND:
            begin
                r.pkg_index   = s.pkg;
                r.byte_offset = s.off[7:0];
                if (s.chunk > 8'd1) begin
                    if (int'(s.off) + int'(s.chunk) <= int'(s.len))
                        r.byte_count = s.chunk;
                    else if ({1'b0, s.len} >= s.off)
                        r.byte_count = s.len - s.off[7:0];
                    else
                        r.byte_count = 8'd0;
                end
                else begin
                    r.byte_count = 8'd1;
                end
            end
            default:
                ;
        endcase
        r.busy_res = (s.ph != PH_IDLE);
        r.phase    = s.ph;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (err_count < PRINT_CAP)
            $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // ---------------------------------------------------------------------
    // Stimulus planning. Every queued item is also run through the planning
    // copy of the state, so later items know the expected toggle.
    // ---------------------------------------------------------------------
    task automatic queue_item(input item_t it);
        plan_scratch = next_descriptor(plan_st, it, plan_mw);
        item_backlog.push_back(it);
    endtask

    // confirm with the toggle the sender expects, or the opposite one
    task automatic queue_confirm(input logic good);
        logic b;
        b = good ? plan_st.exp_c : ~plan_st.exp_c;
        queue_item(mk_item(FUNC_CONFIRM, 8'($urandom), 8'($urandom), b));
    endtask

    // start that passes the package limit; mostly small chunks so that
    // transfers run through many packages
    function automatic item_t valid_start();
        logic [7:0] ch;
        int         top;
        if ($urandom_range(0, 2) == 0)
            ch = 8'($urandom_range(1, 255));
        else
            ch = 8'($urandom_range(1, 20));
        top = MAX_PKG * ch - 1;
        if (top > 255)
            top = 255;
        return mk_item(FUNC_START, 8'($urandom_range(0, top)), ch, 1'($urandom));
    endfunction

    task automatic queue_random_item();
        item_t it;
        int    roll;
        roll = $urandom_range(0, 99);
        // default is raw noise over every field and func code
        it = mk_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 1'($urandom));
        if (plan_st.ph == PH_IDLE) begin
            if (roll < 75)
                it = valid_start();
        end
        else begin
            if (roll < 72)
                it = mk_item(FUNC_CONFIRM, 8'($urandom), 8'($urandom), plan_st.exp_c);
            else if (roll < 82)
                it = mk_item(FUNC_CONFIRM, 8'($urandom), 8'($urandom), ~plan_st.exp_c);
            else if (roll < 88)
                it = valid_start();
            else if (roll < 92)
                it = mk_item(FUNC_QUERY, 8'($urandom), 8'($urandom), 1'($urandom));
        end
        queue_item(it);
    endtask

    // Sender holds off until everything queued has gone out and every
    // result beat is back, then lets the pipeline settle.
    task automatic drain_results();
        while (item_backlog.size() != 0 || in_valid || desc_due.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_max_wait(input logic [15:0] v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        plan_mw = v;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Input driver: bursts of random length, random gaps between them.
    // Changes only at the falling edge; in_beat says whether the beat on the
    // bus was taken at the last rising edge.
    // ---------------------------------------------------------------------
    always @(negedge clk)
    begin : src_drive
        logic  nv;
        item_t nxt;
        nv = in_valid;
        if (rst_n) begin
            if (in_valid && in_beat) begin
                void'(item_backlog.pop_front());
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                else if (item_backlog.size() != 0) begin
                    nxt = item_backlog[0];
                    func        <= nxt.func;
                    msg_length  <= nxt.msg_length;
                    chunk_bytes <= nxt.chunk_bytes;
                    confirm_bit <= nxt.confirm_bit;
                    nv = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end
                    else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            in_valid <= nv;
        end
    end

    // ---------------------------------------------------------------------
    // Result side back-pressure: modes of random length - always ready,
    // sparse long stalls, or dense random drops.
    // ---------------------------------------------------------------------
    always @(negedge clk)
    begin : sink_drive
        logic nr;
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 120);
        end
        else begin
            rx_mode_left--;
        end
        nr = 1'b1;
        if (stall_left != 0) begin
            stall_left--;
            nr = 1'b0;
        end
        else if (rx_mode == 1) begin
            if ($urandom_range(0, 19) == 0) begin
                stall_left = $urandom_range(0, 9);
                nr = 1'b0;
            end
        end
        else if (rx_mode == 2) begin
            nr = 1'($urandom_range(0, 1));
        end
        out_ready <= nr;
    end

    // ---------------------------------------------------------------------
    // Monitor at the rising edge: check the outgoing beat against the oldest
    // prediction first, then predict for the input beat taken at this edge.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : beat_check
        result_t want;
        in_beat <= in_valid && in_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (desc_due.size() == 0) begin
                    report_mismatch("result beat with nothing due", 16'd0, 16'd0);
                end
                else begin
                    want = desc_due.pop_front();
                    if (accepted !== want.accepted)
                        report_mismatch("accepted", 16'(accepted), 16'(want.accepted));
                    if (pkg_index !== want.pkg_index)
                        report_mismatch("pkg_index", 16'(pkg_index), 16'(want.pkg_index));
                    if (byte_count !== want.byte_count)
                        report_mismatch("byte_count", 16'(byte_count), 16'(want.byte_count));
                    if (byte_offset !== want.byte_offset)
                        report_mismatch("byte_offset", 16'(byte_offset),
                                        16'(want.byte_offset));
                    if (busy_res !== want.busy_res)
                        report_mismatch("busy_res", 16'(busy_res), 16'(want.busy_res));
                    if (phase !== want.phase)
                        report_mismatch("phase", 16'(phase), 16'(want.phase));
                end
            end
            if (in_valid && in_ready)
                desc_due.push_back(next_descriptor(mon_st,
                    mk_item(func, msg_length, chunk_bytes, confirm_bit), mon_mw));
            if (cfg_wr_en)
                mon_mw = cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------------
    // Run sequence
    // ---------------------------------------------------------------------
    initial
    begin : run_seq
        logic [15:0] mw_list [5];
        int          p;
        int          n;
        mon_st  = sender_reset_state();
        plan_st = sender_reset_state();
        mon_mw  = MAX_WAIT_RESET;
        plan_mw = MAX_WAIT_RESET;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset value of max_wait.
        queue_item(mk_item(FUNC_QUERY, 8'hFF, 8'hFF, 1'b1));
        // confirms while idle are ignored
        queue_item(mk_item(FUNC_CONFIRM, 8'h00, 8'h00, 1'b0));
        queue_item(mk_item(FUNC_CONFIRM, 8'hFF, 8'hFF, 1'b1));
        queue_item(mk_item(FUNC_UNUSED, 8'hFF, 8'hFF, 1'b1));
        // zero chunk size, then one start too many packages long
        queue_item(mk_item(FUNC_START, 8'd100, 8'd0, 1'b0));
        queue_item(mk_item(FUNC_START, 8'd255, 8'd17, 1'b0));
        // chunk size one with an empty message still reports one byte
        queue_item(mk_item(FUNC_START, 8'd0, 8'd1, 1'b0));
        queue_confirm(1'b1);
        queue_confirm(1'b0);
        queue_confirm(1'b1);
        // just under the package limit
        queue_item(mk_item(FUNC_START, 8'd224, 8'd15, 1'b1));
        queue_confirm(1'b1);
        queue_confirm(1'b0);
        queue_item(mk_item(FUNC_QUERY, 8'h00, 8'h00, 1'b0));
        // start while active: resync first
        queue_item(mk_item(FUNC_START, 8'd255, 8'd255, 1'b0));
        queue_confirm(1'b0);
        queue_confirm(1'b1);
        queue_confirm(1'b1);
        queue_item(mk_item(FUNC_START, 8'd255, 8'd18, 1'b1));
        queue_confirm(1'b1);
        queue_confirm(1'b1);
        queue_item(mk_item(FUNC_UNUSED, 8'h00, 8'h00, 1'b0));
        drain_results();

        // Random phases over several max_wait settings, extremes included.
        mw_list[0] = 16'd0;
        mw_list[1] = 16'd1;
        mw_list[2] = MISS_SAT;
        mw_list[3] = 16'($urandom_range(2, 65534));
        mw_list[4] = MAX_WAIT_RESET;
        for (p = 0; p < 5; p++) begin
            write_max_wait(mw_list[p]);
            for (n = 0; n < 360; n++) begin
                queue_random_item();
                // mid-phase hold-off until every result is back
                if (p == 1 && n == 180)
                    drain_results();
            end
            drain_results();
        end

        if (err_count == 0)
            $display("telemetry_stubborn_sender_tb: clean");
        else
            $display("telemetry_stubborn_sender_tb: errors");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin : watchdog
        #100_000_000;
        $display("telemetry_stubborn_sender_tb: errors");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/tss_pkg.sv
sv/tss_engine.sv
sv/telemetry_stubborn_sender.sv
tb/telemetry_stubborn_sender_tb.sv
